@@ hw/rtl/ucd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared types and constants of the undirected cycle detector.
// ----------------------------------------------------------------------------
package ucd_pkg;

	localparam int MaxVertices = 64;
	localparam int VertexW     = 6;
	localparam int CountW      = 7;
	localparam logic [CountW-1:0] CountReset = 7'd64;

	typedef struct packed {
		logic [VertexW-1:0] end_a;
		logic [VertexW-1:0] end_b;
		logic               last_edge;
	} edge_item_t;

	typedef struct packed {
		logic has_cycle;
		logic bad_edge;
	} result_item_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;      // latch incoming edge
		logic rd_in_a;     // read row of incoming end_a
		logic ins_a;       // write row a, read row b
		logic ins_b;       // write row b
		logic root_start;  // begin a walk at the root
		logic root_next;   // advance root
		logic exam;        // examine current row
		logic pop_load;    // reload top after a pop
		logic clr;         // clear one matrix row
		logic done;        // emit result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_ok;
		logic last;
		logic root_done;
		logic root_vis;
		logic found;
		logic cycle;
		logic depth_one;
		logic clr_last;
	} sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/ucd_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ucd_dp
// Datapath: adjacency row memory, walk stack memory, visited mask, counters.
// ----------------------------------------------------------------------------
module ucd_dp #(
	parameter int MAX_VERTICES = ucd_pkg::MaxVertices
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire ucd_pkg::cmd_t          cmd,
	input  wire ucd_pkg::edge_item_t    item,
	input  wire                         cfg_we,
	input  wire [ucd_pkg::CountW-1:0]   cfg_data,
	output ucd_pkg::sts_t               st,
	output logic                        done,
	output ucd_pkg::result_item_t       result
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [MAX_VERTICES-1:0] ONE_ROW = MAX_VERTICES'(1);

	logic [ucd_pkg::CountW-1:0] vc_q;
	logic [VW-1:0]              a_q, b_q, cur_q, pend_q, clr_q;
	logic                       last_q, err_q, cyc_q, pend_v_q;
	logic [CW-1:0]              root_q, depth_q;
	logic [MAX_VERTICES-1:0]    visited_q;

	logic [MAX_VERTICES-1:0]    adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]    adj_rd_q;
	logic [VW-1:0]              stk_mem [MAX_VERTICES];
	logic [VW-1:0]              stk_rd_q;

	logic                       done_q;
	ucd_pkg::result_item_t      res_q;

	logic [CW-1:0]              n;
	logic                       in_ok;
	logic [MAX_VERTICES-1:0]    col_mask, row_cl, live, exam_wd;
	logic                       found, w_vis;
	logic [VW-1:0]              w;
	logic [CW-1:0]              dep_m2;
	logic                       adj_we;
	logic [VW-1:0]              adj_wa, adj_ra;
	logic [MAX_VERTICES-1:0]    adj_wd;
	logic                       stk_we;
	logic [VW-1:0]              stk_wa, stk_wd, stk_ra;

	always_comb begin
		if (int'(vc_q) > MAX_VERTICES) n = CW'(MAX_VERTICES);
		else n = CW'(vc_q);
	end

	assign in_ok = (int'(item.end_a) < int'(n)) && (int'(item.end_b) < int'(n));

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) col_mask[i] = (i < int'(n));
	end

	// pending clear is the back edge to the parent, dropped on first visit
	assign row_cl = adj_rd_q & ~(pend_v_q ? (ONE_ROW << pend_q) : '0);
	assign live   = row_cl & col_mask;
	assign found  = |live;

	always_comb begin
		w = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (live[i]) w = VW'(i);
		end
	end

	assign w_vis   = visited_q[w];
	assign exam_wd = row_cl & ~(found ? (ONE_ROW << w) : '0);
	assign dep_m2  = depth_q - CW'(2);

	always_comb begin
		adj_we = 1'b0;
		adj_wa = cur_q;
		adj_wd = exam_wd;
		adj_ra = w;
		if (cmd.rd_in_a) adj_ra = VW'(item.end_a);
		if (cmd.ins_a) begin
			adj_we = 1'b1;
			adj_wa = a_q;
			adj_wd = adj_rd_q | (ONE_ROW << b_q);
			adj_ra = b_q;
		end
		if (cmd.ins_b) begin
			adj_we = 1'b1;
			adj_wa = b_q;
			adj_wd = adj_rd_q | (ONE_ROW << a_q);
		end
		if (cmd.exam) adj_we = 1'b1;
		if (cmd.root_start) adj_ra = root_q[VW-1:0];
		if (cmd.pop_load) adj_ra = stk_rd_q;
		if (cmd.clr) begin
			adj_we = 1'b1;
			adj_wa = clr_q;
			adj_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_wa] <= adj_wd;
		adj_rd_q <= adj_mem[adj_ra];
	end

	always_comb begin
		stk_we = 1'b0;
		stk_wa = depth_q[VW-1:0];
		stk_wd = w;
		stk_ra = dep_m2[VW-1:0];
		if (cmd.root_start) begin
			stk_we = 1'b1;
			stk_wa = '0;
			stk_wd = root_q[VW-1:0];
		end
		if (cmd.exam && found && !w_vis) stk_we = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		stk_rd_q <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q      <= ucd_pkg::CountReset;
			last_q    <= 1'b0;
			err_q     <= 1'b0;
			cyc_q     <= 1'b0;
			pend_v_q  <= 1'b0;
			root_q    <= '0;
			depth_q   <= '0;
			visited_q <= '0;
			clr_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.done;
			if (cfg_we) vc_q <= cfg_data;
			if (cmd.accept) begin
				last_q <= item.last_edge;
				err_q  <= err_q | !in_ok;
			end
			if (cmd.root_start) begin
				visited_q[root_q[VW-1:0]] <= 1'b1;
				depth_q  <= CW'(1);
				pend_v_q <= 1'b0;
			end
			if (cmd.root_next) root_q <= root_q + CW'(1);
			if (cmd.exam) begin
				if (found) begin
					if (w_vis) cyc_q <= 1'b1;
					else begin
						visited_q[w] <= 1'b1;
						depth_q  <= depth_q + CW'(1);
						pend_v_q <= 1'b1;
					end
				end else begin
					depth_q <= depth_q - CW'(1);
				end
			end
			if (cmd.pop_load) pend_v_q <= 1'b0;
			if (cmd.clr) begin
				visited_q <= '0;
				err_q     <= 1'b0;
				cyc_q     <= 1'b0;
				root_q    <= '0;
				depth_q   <= '0;
				clr_q     <= clr_q + VW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_q <= VW'(item.end_a);
			b_q <= VW'(item.end_b);
		end
		if (cmd.root_start) cur_q <= root_q[VW-1:0];
		if (cmd.exam && found && !w_vis) begin
			cur_q  <= w;
			pend_q <= cur_q;
		end
		if (cmd.pop_load) cur_q <= stk_rd_q;
		if (cmd.done) begin
			res_q.has_cycle <= cyc_q;
			res_q.bad_edge  <= err_q;
		end
	end

	assign st.in_ok     = in_ok;
	assign st.last      = last_q;
	assign st.root_done = root_q >= n;
	assign st.root_vis  = visited_q[root_q[VW-1:0]];
	assign st.found     = found;
	assign st.cycle     = found && w_vis;
	assign st.depth_one = depth_q == CW'(1);
	assign st.clr_last  = clr_q == VW'(MAX_VERTICES - 1);

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

@@ hw/rtl/ucd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ucd_ctrl
// Controller: edge insertion, root scan, depth-first walk, matrix clear.
// ----------------------------------------------------------------------------
module ucd_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire            last_edge,
	input  wire ucd_pkg::sts_t st,
	output ucd_pkg::cmd_t  cmd,
	output logic           busy
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_INSA = 3'd2;
	localparam logic [2:0] S_INSB = 3'd3;
	localparam logic [2:0] S_ROOT = 3'd4;
	localparam logic [2:0] S_EXAM = 3'd5;
	localparam logic [2:0] S_POP  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (st.in_ok) begin
						cmd.rd_in_a = 1'b1;
						state_d = S_INSA;
					end else if (last_edge) begin
						state_d = S_ROOT;
					end
				end
			end
			S_INSA: begin
				cmd.ins_a = 1'b1;
				state_d = S_INSB;
			end
			S_INSB: begin
				cmd.ins_b = 1'b1;
				state_d = st.last ? S_ROOT : S_IDLE;
			end
			S_ROOT: begin
				if (st.root_done) state_d = S_DONE;
				else if (!st.root_vis) begin
					cmd.root_start = 1'b1;
					state_d = S_EXAM;
				end else cmd.root_next = 1'b1;
			end
			S_EXAM: begin
				cmd.exam = 1'b1;
				if (st.cycle) state_d = S_DONE;
				else if (st.found) state_d = S_EXAM;
				else if (st.depth_one) begin
					cmd.root_next = 1'b1;
					state_d = S_ROOT;
				end else state_d = S_POP;
			end
			S_POP: begin
				cmd.pop_load = 1'b1;
				state_d = S_EXAM;
			end
			S_DONE: begin
				cmd.done = 1'b1;
				state_d = S_CLR;
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end

	assign busy = state_q != S_IDLE;

endmodule
`default_nettype wire

@@ hw/rtl/undirected_cycle_detect.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// undirected_cycle_detect
// Cycle detector for undirected graphs loaded one edge per item.
// ----------------------------------------------------------------------------
// Usage: drive item with start while busy is low; the item is taken at that
// edge. An in-range edge does a row read-modify-write of both endpoints
// in the adjacency row memory, which reads one row while writing another;
// an edge with an endpoint at or beyond vertex_count is only flagged.
// The item with last_edge set starts the search: a depth-first walk over
// every component, one matrix row per cycle except while a root is tried
// or the stack is popped. The single result then appears with done for
// one cycle, and the matrix is cleared row by row before busy drops.
// After reset busy stays high for the same clear pass; vertex_count resets
// to 64 and may be written through cfg_we/cfg_data at any time the block
// is idle. The receiver cannot stall: done is a strobe.
// ----------------------------------------------------------------------------
module undirected_cycle_detect #(
	parameter int MAX_VERTICES = ucd_pkg::MaxVertices
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire ucd_pkg::edge_item_t   item,
	output logic                       done,
	output ucd_pkg::result_item_t      result,
	input  wire                        cfg_we,
	input  wire [ucd_pkg::CountW-1:0]  cfg_data
);

	ucd_pkg::cmd_t cmd;
	ucd_pkg::sts_t st;

	ucd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_edge (item.last_edge),
		.st        (st),
		.cmd       (cmd),
		.busy      (busy)
	);

	ucd_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.st       (st),
		.done     (done),
		.result   (result)
	);

	// result is followed by the clear pass, so the block is still busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result while idle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result repeated");

	a_no_result_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.last_edge) |=> !done)
		else $error("result after non-last item");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for undirected_cycle_detect: streams edge items with
// random gaps, tracks the graph in a local DFS predictor and checks every
// has_cycle/bad_edge result in order against the predicted queue.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CycleLimit = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	ucd_pkg::edge_item_t item = '0;
	logic done;
	ucd_pkg::result_item_t result;
	logic cfg_we = 1'b0;
	logic [ucd_pkg::CountW-1:0] cfg_data = '0;
	int cycles = 0;
	int n_items = 0;
	int n_graphs = 0;

	class cycle_scoreboard;
		logic [ucd_pkg::MaxVertices-1:0] adj [ucd_pkg::MaxVertices];
		logic [ucd_pkg::MaxVertices-1:0] seen;
		int stack [ucd_pkg::MaxVertices];
		int depth;
		bit err;
		logic [ucd_pkg::CountW-1:0] count;
		ucd_pkg::result_item_t pending [$];
		int errors;
		int n_checked;
		int n_cycles;

		function new();
			clear_graph();
			count = ucd_pkg::CountReset;
			errors = 0;
			n_checked = 0;
			n_cycles = 0;
		endfunction

		function void clear_graph();
			foreach (adj[i]) adj[i] = '0;
			seen = '0;
			depth = 0;
			err = 0;
		endfunction

		function int active();
			return (count > ucd_pkg::MaxVertices) ? ucd_pkg::MaxVertices : int'(count);
		endfunction

		function bit walk_from(int root, int n);
			int v, w;
			bit found;
			seen[root] = 1'b1;
			stack[0] = root;
			depth = 1;
			while (depth > 0) begin
				v = stack[depth-1];
				found = 0;
				for (w = 0; w < n; w++) begin
					if (adj[v][w]) begin
						found = 1;
						break;
					end
				end
				if (!found) begin
					depth--;
					continue;
				end
				adj[v][w] = 1'b0;
				adj[w][v] = 1'b0;
				if (seen[w])
					return 1;
				seen[w] = 1'b1;
				if (depth < ucd_pkg::MaxVertices) begin
					stack[depth] = w;
					depth++;
				end
			end
			return 0;
		endfunction

		function bit find_cycle(int n);
			for (int v = 0; v < n; v++)
				if (adj[v][v])
					return 1;
			for (int v = 0; v < n; v++)
				if (!seen[v] && walk_from(v, n))
					return 1;
			return 0;
		endfunction

		function void note(ucd_pkg::edge_item_t it);
			int n;
			ucd_pkg::result_item_t r;
			n = active();
			if (it.end_a >= n || it.end_b >= n) begin
				err = 1;
			end else begin
				adj[it.end_a][it.end_b] = 1'b1;
				adj[it.end_b][it.end_a] = 1'b1;
			end
			if (it.last_edge) begin
				r.has_cycle = find_cycle(n);
				r.bad_edge = err;
				pending.push_back(r);
				clear_graph();
			end
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		task check(ucd_pkg::result_item_t got);
			ucd_pkg::result_item_t exp;
			if (pending.size() == 0) begin
				report("result with no expectation");
				return;
			end
			exp = pending.pop_front();
			n_checked++;
			if (exp.has_cycle)
				n_cycles++;
			if (got.has_cycle !== exp.has_cycle)
				report($sformatf("has_cycle %b, expected %b", got.has_cycle, exp.has_cycle));
			if (got.bad_edge !== exp.bad_edge)
				report($sformatf("bad_edge %b, expected %b", got.bad_edge, exp.bad_edge));
		endtask
	endclass

	cycle_scoreboard sb = new();

	undirected_cycle_detect dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("undirected_cycle_detect test failed");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check(result);

	task send_edge(int a, int b, bit last, int gap);
		ucd_pkg::edge_item_t it;
		it.end_a = a[ucd_pkg::VertexW-1:0];
		it.end_b = b[ucd_pkg::VertexW-1:0];
		it.last_edge = last;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sb.note(it);
		n_items++;
		if (last)
			n_graphs++;
	endtask

	// drain results, let a trailing non-last edge finish, then see busy low
	task wait_idle();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task set_count(int v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= v[ucd_pkg::CountW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.count = v[ucd_pkg::CountW-1:0];
	endtask

	function int draw_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
	endfunction

	task random_graph();
		int n, span, k, a, b;
		n = sb.active();
		span = (n == 0) ? 1 : $urandom_range(1, (n < 12) ? n : 12);
		k = $urandom_range(1, 10);
		for (int i = 0; i < k; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				a = $urandom_range(0, 63);
				b = $urandom_range(0, 63);
			end else begin
				a = $urandom_range(0, span - 1);
				b = $urandom_range(0, span - 1);
			end
			send_edge(a, b, i == k - 1, draw_gap());
		end
	endtask

	initial begin
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		set_count(64);
		send_edge(0, 63, 1, 0);
		send_edge(5, 5, 1, 2);
		send_edge(0, 1, 0, 0);
		send_edge(1, 2, 0, 0);
		send_edge(2, 0, 1, 0);
		send_edge(3, 4, 0, 1);
		send_edge(4, 3, 1, 0);
		send_edge(63, 63, 1, 0);
		set_count(10);
		send_edge(63, 2, 0, 0);
		send_edge(2, 3, 1, 0);
		set_count(1);
		send_edge(0, 0, 1, 0);
		set_count(0);
		send_edge(0, 0, 1, 0);
		set_count(127);
		send_edge(63, 62, 0, 0);
		send_edge(62, 63, 1, 0);
		// count lowered mid-graph: the triangle above the new count is not walked
		set_count(64);
		send_edge(40, 41, 0, 0);
		send_edge(41, 42, 0, 0);
		send_edge(42, 40, 0, 0);
		set_count(20);
		send_edge(1, 2, 1, 0);

		// random phases
		while (n_items < 1800) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				set_count(64);
			else if (pick == 1)
				set_count($urandom_range(0, 1) ? 0 : 1);
			else if (pick == 2)
				set_count($urandom_range(0, 127));
			else if (pick == 3)
				set_count(127);
			else
				set_count($urandom_range(2, 16));
			repeat ($urandom_range(2, 8)) random_graph();
		end

		wait_idle();
		repeat (200) @(posedge clk);
		while (sb.pending.size() != 0) begin
			void'(sb.pending.pop_front());
			sb.report("expected result never arrived");
		end
		$display("sent %0d edges in %0d graphs over several vertex counts", n_items, n_graphs);
		$display("checked %0d results, %0d with a cycle", sb.n_checked, sb.n_cycles);
		if (sb.errors == 0)
			$display("undirected_cycle_detect test passed");
		else
			$display("undirected_cycle_detect test failed");
		$finish;
	end
endmodule

@@ filelist.f @@
hw/rtl/ucd_pkg.sv
hw/rtl/ucd_dp.sv
hw/rtl/ucd_ctrl.sv
hw/rtl/undirected_cycle_detect.sv
dv/tb_top.sv
